// ----- rtl/core/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
// Used by the cell row (spq_cell) and the top level (sorted_priority_queue).
package spq_pkg;

    // Default number of cells in the row
    localparam int DEPTH_DEF = 16;

    // Field widths
    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 16;
    localparam int OCC_W   = 5;

    // Operation codes carried by an input beat
    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_PEEK    = 2'd2
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Per-cycle command broadcast to every cell
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_SHIFT
    } cell_cmd_t;

    // One stored pair
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } entry_t;

    // Broadcast control bundle: command plus the item being inserted
    typedef struct packed {
        cell_cmd_t cmd;
        entry_t    item;
    } cell_ctl_t;

    // Value returned by dequeue or peek on an empty queue
    localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = '1;

endpackage

// ----- rtl/core/spq_cell.sv -----
// One cell of the sorted row: holds a value/priority pair and trades it with
// its neighbors. Depends on spq_pkg for the entry and control types.
module spq_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic              clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  logic [CNT_W-1:0]  count,
    input  spq_pkg::entry_t   prev_entry,
    input  logic              prev_ge,
    input  spq_pkg::entry_t   next_entry,
    output spq_pkg::entry_t   entry,
    output logic              ge
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;

    // Cell holds a live entry when its slot lies below the fill count
    assign occupied = (count > CNT_W'(INDEX));

    // Live entry ranks at or above the incoming item: it stays put on insert
    assign ge = occupied && (entry_reg.prio >= ctl.item.prio);

    // Insert: keep, take the new item, or take the upper neighbor's entry.
    // Shift: take the lower neighbor's entry (dequeue moves all up by one).
    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.cmd)
            CMD_INSERT:
            begin
                if (ge)
                    entry_next = entry_reg;
                else if (prev_ge)
                    entry_next = ctl.item;
                else
                    entry_next = prev_entry;
            end
            CMD_SHIFT:
            begin
                entry_next = next_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Payload storage, no reset needed
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- rtl/core/sorted_priority_queue.sv -----
// Sorted priority queue: a row of DEPTH cells kept in descending priority.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   Input channel (item_valid / item_stall) carries one operation per beat:
//   enqueue (item_value, item_priority), dequeue head, or peek head.
//   Output channel (result_valid / result_stall) returns exactly one result
//   beat per input beat, in order: head_value, status, occupancy, empty_flag.
//   The result is registered: it appears in the cycle after the beat is taken.
//   Throughput: one operation per cycle unless item_stall is raised. Every
//   cell compares its priority against the incoming item in parallel and
//   shifts with its neighbor, so the row updates at once at any fill level.
//   Equal priorities keep arrival order (new item goes behind them).
//   A full queue drops an enqueue and reports status 2; dequeue or peek on
//   an empty queue returns -1 with status 1.
//   Reset: clears the fill count and the output valid; cell contents are
//   left as they are and are never read until written.
//   Stall: while a result waits under result_stall, item_stall is raised,
//   so no input beat is taken until the pending result leaves; the output
//   register then refills in the same cycle it drains.
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [1:0]                          operation,
    input  logic signed [spq_pkg::VALUE_W-1:0]  item_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   item_priority,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [spq_pkg::VALUE_W-1:0]  head_value,
    output logic [1:0]                          status,
    output logic [spq_pkg::OCC_W-1:0]           occupancy,
    output logic                                empty_flag
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     accept;
    logic                     full;
    logic                     empty;
    cell_ctl_t                ctl;
    entry_t                   cell_entry [DEPTH];
    logic                     cell_ge [DEPTH];

    logic                     result_valid_reg;
    logic signed [VALUE_W-1:0] head_value_reg;
    logic signed [VALUE_W-1:0] head_value_next;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic [OCC_W-1:0]         occupancy_reg;
    logic                     empty_flag_reg;
    logic [CNT_W+OCC_W-1:0]   count_ext;

    // Handshake: take a beat unless a result is stuck at the output
    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // Decode the operation into a row command, new count and result fields
    always_comb
    begin
        ctl.cmd         = CMD_HOLD;
        ctl.item.value  = item_value;
        ctl.item.prio   = item_priority;
        count_next      = count_reg;
        head_value_next = '0;
        status_next     = ST_OK;
        case (operation)
            OP_ENQUEUE:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctl.cmd    = accept ? CMD_INSERT : CMD_HOLD;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_DEQUEUE, OP_PEEK:
            begin
                if (empty)
                begin
                    head_value_next = EMPTY_VALUE;
                    status_next     = ST_EMPTY;
                end
                else
                begin
                    head_value_next = cell_entry[0].value;
                    if (operation == OP_DEQUEUE)
                    begin
                        ctl.cmd    = accept ? CMD_SHIFT : CMD_HOLD;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                head_value_next = '0;
            end
        endcase
    end

    // Row of cells, each wired to its neighbors
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t prev_e;
        logic   prev_g;
        entry_t next_e;

        if (i == 0)
        begin : g_first
            assign prev_e = ctl.item;
            assign prev_g = 1'b1;
        end
        else
        begin : g_mid
            assign prev_e = cell_entry[i-1];
            assign prev_g = cell_ge[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_e = cell_entry[i];
        end
        else
        begin : g_inner
            assign next_e = cell_entry[i+1];
        end

        spq_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .count      (count_reg),
            .prev_entry (prev_e),
            .prev_ge    (prev_g),
            .next_entry (next_e),
            .entry      (cell_entry[i]),
            .ge         (cell_ge[i])
        );
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (accept)
            count_reg <= count_next;
    end

    // Occupancy reported as the count masked to the field width
    assign count_ext = {{OCC_W{1'b0}}, count_next};

    // Output register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (accept)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    // Output register: payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_value_reg <= head_value_next;
            status_reg     <= status_next;
            occupancy_reg  <= count_ext[OCC_W-1:0];
            empty_flag_reg <= (count_next == '0);
        end
    end

    assign result_valid = result_valid_reg;
    assign head_value   = head_value_reg;
    assign status       = status_reg;
    assign occupancy    = occupancy_reg;
    assign empty_flag   = empty_flag_reg;

    // Fill count never exceeds the number of cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // Every accepted beat yields a pending result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid_reg)
        else $error("accepted beat produced no result");

    // A dequeue on a non-empty queue removes exactly one entry
    a_dequeue_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_DEQUEUE && !empty)
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("dequeue did not lower fill count by one");

    // A peek leaves the head cell and the count untouched
    a_peek_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_PEEK)
        |=> $stable(count_reg) && $stable(cell_entry[0]))
        else $error("peek changed queue contents");

    // Empty status always carries the empty marker value
    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && status_reg == ST_EMPTY)
        |-> head_value_reg == EMPTY_VALUE && empty_flag_reg)
        else $error("empty status without empty marker");

endmodule
